// ===== sv/pwmd_pkg.sv =====
// Package for the peer-wire message deframer: result and error codes,
// the result record, configuration register indexes and reset values.
// No dependencies; every other file of the block uses it.
package pwmd_pkg;

    // Default width of the frame length counter.
    localparam int LENGTH_BITS_DEFAULT = 32;

    // Configuration port widths, register indexes and reset values.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 21;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_FRAME    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_BITFIELD = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0]  MAX_FRAME_RESET    = 21'd262153;
    localparam logic [CFG_DATA_BITS-1:0]  MAX_BITFIELD_RESET = 21'd262144;

    // Standard message identifiers.
    localparam logic [7:0] ID_LAST_CONTROL = 8'd3;
    localparam logic [7:0] ID_HAVE         = 8'd4;
    localparam logic [7:0] ID_BITFIELD     = 8'd5;
    localparam logic [7:0] ID_REQUEST      = 8'd6;
    localparam logic [7:0] ID_PIECE        = 8'd7;
    localparam logic [7:0] ID_CANCEL       = 8'd8;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_KEEPALIVE   = 3'd0,
        KIND_DONE        = 3'd1,
        KIND_BITFIELD    = 3'd2,
        KIND_PIECE       = 3'd3,
        KIND_EMPTY_PIECE = 3'd4,
        KIND_ERROR       = 3'd5
    } kind_t;

    // Error codes carried on an error result.
    typedef enum logic [1:0] {
        ERR_TOO_LONG     = 2'd0,
        ERR_FIXED_LENGTH = 2'd1,
        ERR_PIECE_SHORT  = 2'd2,
        ERR_BITFIELD     = 2'd3
    } err_t;

    // One result record.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_id;
        logic [31:0] piece_num;
        logic [31:0] block_begin;
        logic [7:0]  data_byte;
        logic [19:0] byte_offset;
        logic        last;
        err_t        error_code;
    } result_t;

endpackage

// ===== sv/pwmd_if.sv =====
// Channel interfaces of the peer-wire message deframer: input bytes,
// results and configuration writes. Depends on pwmd_pkg.

// Input byte stream channel.
interface pwmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// Result channel.
interface pwmd_result_if;
    logic              valid;
    logic              ready;
    pwmd_pkg::kind_t   kind;
    logic [7:0]        msg_id;
    logic [31:0]       piece_num;
    logic [31:0]       block_begin;
    logic [7:0]        data_byte;
    logic [19:0]       byte_offset;
    logic              last;
    pwmd_pkg::err_t    error_code;

    modport source (output valid, output kind, output msg_id, output piece_num,
                    output block_begin, output data_byte, output byte_offset,
                    output last, output error_code, input ready);
    modport sink (input valid, input kind, input msg_id, input piece_num,
                  input block_begin, input data_byte, input byte_offset,
                  input last, input error_code, output ready);
endinterface

// Configuration write channel.
interface pwmd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pwmd_pkg::CFG_INDEX_BITS-1:0] index;
    logic [pwmd_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pwmd_parser.sv =====
// Frame parser of the peer-wire message deframer: holds the parse state and
// turns each accepted byte into at most one result. Depends on pwmd_pkg.
module pwmd_parser #(
    parameter int LENGTH_BITS = pwmd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [7:0]                         stream_byte,
    input  logic [pwmd_pkg::CFG_DATA_BITS-1:0] max_frame_length,
    input  logic [pwmd_pkg::CFG_DATA_BITS-1:0] max_bitfield_length,
    output logic                               res_valid,
    output pwmd_pkg::result_t                  res
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_ID,
        PH_HAVE,
        PH_PHDR,
        PH_BITF,
        PH_PDATA,
        PH_SKIP,
        PH_DEAD
    } phase_t;

    // Largest prefix that the length counter can hold.
    localparam logic [32:0] LEN_LIMIT = (33'd1 << LENGTH_BITS) - 33'd1;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             hdr_count_reg, hdr_count_next;
    logic [31:0]            len_shift_reg, len_shift_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [7:0]             id_reg, id_next;
    logic [31:0]            index_reg, index_next;
    logic [31:0]            begin_reg, begin_next;
    logic [19:0]            offset_reg, offset_next;

    logic [LENGTH_BITS-1:0] frame_len;
    logic                   too_long;
    logic                   rem_last;

    // The length prefix stays in the shift register for the rest of the frame.
    assign frame_len = len_shift_reg[LENGTH_BITS-1:0];
    assign too_long  = (len_shift_next > {11'd0, max_frame_length})
                    || ({1'b0, len_shift_next} > LEN_LIMIT);
    assign rem_last  = (remaining_reg == LENGTH_BITS'(1));

    // Next state and result for the accepted byte.
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        len_shift_next = len_shift_reg;
        remaining_next = remaining_reg;
        id_next        = id_reg;
        index_next     = index_reg;
        begin_next     = begin_reg;
        offset_next    = offset_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.kind       = pwmd_pkg::KIND_KEEPALIVE;
        res.error_code = pwmd_pkg::ERR_TOO_LONG;

        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    len_shift_next = {len_shift_reg[23:0], stream_byte};
                    if (hdr_count_reg != 2'd3)
                    begin
                        hdr_count_next = hdr_count_reg + 2'd1;
                    end
                    else
                    begin
                        hdr_count_next = 2'd0;
                        if (too_long)
                        begin
                            phase_next     = PH_DEAD;
                            res_valid      = 1'b1;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.last       = 1'b1;
                            res.error_code = pwmd_pkg::ERR_TOO_LONG;
                        end
                        else if (len_shift_next == 32'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = pwmd_pkg::KIND_KEEPALIVE;
                            res.last  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                end

                PH_ID:
                begin
                    id_next     = stream_byte;
                    index_next  = 32'd0;
                    begin_next  = 32'd0;
                    offset_next = 20'd0;
                    res.msg_id  = stream_byte;
                    res.last    = 1'b1;
                    if (stream_byte <= pwmd_pkg::ID_LAST_CONTROL)
                    begin
                        res_valid = 1'b1;
                        if (frame_len != LENGTH_BITS'(1))
                        begin
                            phase_next     = PH_DEAD;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.error_code = pwmd_pkg::ERR_FIXED_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                            res.kind   = pwmd_pkg::KIND_DONE;
                        end
                    end
                    else if (stream_byte == pwmd_pkg::ID_HAVE)
                    begin
                        if (frame_len != LENGTH_BITS'(5))
                        begin
                            phase_next     = PH_DEAD;
                            res_valid      = 1'b1;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.error_code = pwmd_pkg::ERR_FIXED_LENGTH;
                        end
                        else
                        begin
                            remaining_next = LENGTH_BITS'(4);
                            phase_next     = PH_HAVE;
                        end
                    end
                    else if (stream_byte == pwmd_pkg::ID_REQUEST
                          || stream_byte == pwmd_pkg::ID_CANCEL)
                    begin
                        if (frame_len != LENGTH_BITS'(13))
                        begin
                            phase_next     = PH_DEAD;
                            res_valid      = 1'b1;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.error_code = pwmd_pkg::ERR_FIXED_LENGTH;
                        end
                        else
                        begin
                            remaining_next = LENGTH_BITS'(12);
                            phase_next     = PH_SKIP;
                        end
                    end
                    else if (stream_byte == pwmd_pkg::ID_BITFIELD)
                    begin
                        if ((32'(frame_len) - 32'd1) > 32'(max_bitfield_length))
                        begin
                            phase_next     = PH_DEAD;
                            res_valid      = 1'b1;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.error_code = pwmd_pkg::ERR_BITFIELD;
                        end
                        else if (frame_len == LENGTH_BITS'(1))
                        begin
                            phase_next = PH_LEN;
                            res_valid  = 1'b1;
                            res.kind   = pwmd_pkg::KIND_DONE;
                        end
                        else
                        begin
                            remaining_next = frame_len - LENGTH_BITS'(1);
                            phase_next     = PH_BITF;
                        end
                    end
                    else if (stream_byte == pwmd_pkg::ID_PIECE)
                    begin
                        if (frame_len < LENGTH_BITS'(9))
                        begin
                            phase_next     = PH_DEAD;
                            res_valid      = 1'b1;
                            res.kind       = pwmd_pkg::KIND_ERROR;
                            res.error_code = pwmd_pkg::ERR_PIECE_SHORT;
                        end
                        else
                        begin
                            remaining_next = LENGTH_BITS'(8);
                            phase_next     = PH_PHDR;
                        end
                    end
                    else
                    begin
                        // Unknown message: skip the payload.
                        if (frame_len == LENGTH_BITS'(1))
                        begin
                            phase_next = PH_LEN;
                            res_valid  = 1'b1;
                            res.kind   = pwmd_pkg::KIND_DONE;
                        end
                        else
                        begin
                            remaining_next = frame_len - LENGTH_BITS'(1);
                            phase_next     = PH_SKIP;
                        end
                    end
                end

                PH_HAVE:
                begin
                    index_next     = {index_reg[23:0], stream_byte};
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                    if (rem_last)
                    begin
                        phase_next    = PH_LEN;
                        res_valid     = 1'b1;
                        res.kind      = pwmd_pkg::KIND_DONE;
                        res.msg_id    = id_reg;
                        res.piece_num = index_next;
                        res.last      = 1'b1;
                    end
                end

                PH_PHDR:
                begin
                    // Four index bytes, then four begin bytes.
                    if (remaining_reg > LENGTH_BITS'(4))
                    begin
                        index_next = {index_reg[23:0], stream_byte};
                    end
                    else
                    begin
                        begin_next = {begin_reg[23:0], stream_byte};
                    end
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                    if (rem_last)
                    begin
                        if (frame_len == LENGTH_BITS'(9))
                        begin
                            phase_next      = PH_LEN;
                            res_valid       = 1'b1;
                            res.kind        = pwmd_pkg::KIND_EMPTY_PIECE;
                            res.msg_id      = id_reg;
                            res.piece_num   = index_next;
                            res.block_begin = begin_next;
                            res.last        = 1'b1;
                        end
                        else
                        begin
                            remaining_next = frame_len - LENGTH_BITS'(9);
                            phase_next     = PH_PDATA;
                        end
                    end
                end

                PH_BITF:
                begin
                    remaining_next  = remaining_reg - LENGTH_BITS'(1);
                    offset_next     = offset_reg + 20'd1;
                    res_valid       = 1'b1;
                    res.kind        = pwmd_pkg::KIND_BITFIELD;
                    res.msg_id      = id_reg;
                    res.data_byte   = stream_byte;
                    res.byte_offset = offset_reg;
                    res.last        = rem_last;
                    if (rem_last)
                    begin
                        phase_next = PH_LEN;
                    end
                end

                PH_PDATA:
                begin
                    remaining_next  = remaining_reg - LENGTH_BITS'(1);
                    offset_next     = offset_reg + 20'd1;
                    res_valid       = 1'b1;
                    res.kind        = pwmd_pkg::KIND_PIECE;
                    res.msg_id      = id_reg;
                    res.piece_num   = index_reg;
                    res.block_begin = begin_reg;
                    res.data_byte   = stream_byte;
                    res.byte_offset = offset_reg;
                    res.last        = rem_last;
                    if (rem_last)
                    begin
                        phase_next = PH_LEN;
                    end
                end

                PH_SKIP:
                begin
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                    if (rem_last)
                    begin
                        phase_next = PH_LEN;
                        res_valid  = 1'b1;
                        res.kind   = pwmd_pkg::KIND_DONE;
                        res.msg_id = id_reg;
                        res.last   = 1'b1;
                    end
                end

                PH_DEAD:
                begin
                    // Input is dropped until reset.
                end

                default:
                begin
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            hdr_count_reg <= 2'd0;
            len_shift_reg <= 32'd0;
            remaining_reg <= '0;
            id_reg        <= 8'd0;
            index_reg     <= 32'd0;
            begin_reg     <= 32'd0;
            offset_reg    <= 20'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            len_shift_reg <= len_shift_next;
            remaining_reg <= remaining_next;
            id_reg        <= id_next;
            index_reg     <= index_next;
            begin_reg     <= begin_next;
            offset_reg    <= offset_next;
        end
    end

endmodule

// ===== sv/pwmd_out_skid.sv =====
// Two-entry result buffer of the peer-wire message deframer: an output
// register with a skid entry behind it. Depends on pwmd_pkg.
module pwmd_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pwmd_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output pwmd_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    pwmd_pkg::result_t main_data_reg;
    pwmd_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== sv/peer_wire_message_deframer.sv =====
// Peer-wire message deframer: top level with configuration registers,
// frame parser and result buffer. Depends on pwmd_pkg, pwmd_if,
// pwmd_parser and pwmd_out_skid.
//
// The byte_in channel takes one byte of the received stream per
// transaction. Each byte is parsed in the cycle it is accepted, and the
// result it causes, if any, is registered in the output register, or in
// the skid entry while the output register holds a waiting result. The
// block takes one byte every cycle while the result buffer has room.
// Results go through an output register with one skid entry, so a byte
// is still taken while one result waits on a stalled receiver; byte_in
// ready drops only while both entries are full, and returns once the
// receiver takes a result. The cfg channel is always ready and writes the
// maximum frame length (index 0) and maximum bitfield length (index 1);
// other indexes are ignored. Reset clears the parser to await a length
// prefix, empties the result buffer and restores the register defaults.
// After an error result the parser drops all input until reset.
module peer_wire_message_deframer #(
    parameter int LENGTH_BITS = pwmd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    pwmd_cfg_if.sink      cfg,
    pwmd_byte_if.sink     byte_in,
    pwmd_result_if.source result_out
);

    logic [pwmd_pkg::CFG_DATA_BITS-1:0] max_frame_reg;
    logic [pwmd_pkg::CFG_DATA_BITS-1:0] max_bitfield_reg;
    logic                               accept;
    logic                               res_valid;
    pwmd_pkg::result_t                  res;
    logic                               can_push;
    pwmd_pkg::result_t                  out_data;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg    <= pwmd_pkg::MAX_FRAME_RESET;
            max_bitfield_reg <= pwmd_pkg::MAX_BITFIELD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pwmd_pkg::CFG_MAX_FRAME:    max_frame_reg    <= cfg.data;
                pwmd_pkg::CFG_MAX_BITFIELD: max_bitfield_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Byte transactions are taken whenever the result buffer has room.
    assign byte_in.ready = can_push;
    assign accept        = byte_in.valid && can_push;

    pwmd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .stream_byte        (byte_in.stream_byte),
        .max_frame_length   (max_frame_reg),
        .max_bitfield_length(max_bitfield_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    pwmd_out_skid u_out_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_data(res),
        .can_push (can_push),
        .out_valid(result_out.valid),
        .out_ready(result_out.ready),
        .out_data (out_data)
    );

    // Result channel payload.
    assign result_out.kind        = out_data.kind;
    assign result_out.msg_id      = out_data.msg_id;
    assign result_out.piece_num   = out_data.piece_num;
    assign result_out.block_begin = out_data.block_begin;
    assign result_out.data_byte   = out_data.data_byte;
    assign result_out.byte_offset = out_data.byte_offset;
    assign result_out.last        = out_data.last;
    assign result_out.error_code  = out_data.error_code;

endmodule

// ===== tb/peer_wire_message_deframer_test.sv =====
// Testbench for the peer-wire message deframer: drives framed byte streams under
// several register settings and checks every result against a built-in parser model or a hand-written expectation.
// Depends on pwmd_pkg, the channel interfaces in pwmd_if and the deframer top level.
`timescale 1ns / 1ps

module peer_wire_message_deframer_test;

    // Parser phases of the local model.
    typedef enum logic [2:0] {
        AWAIT_LEN,
        AWAIT_ID,
        HAVE_INDEX,
        PIECE_HEADER,
        BITFIELD_DATA,
        PIECE_DATA,
        SKIP_PAYLOAD,
        DEAD
    } phase_t;

    // One stream byte, with an optional hand-written expectation.
    typedef struct {
        logic [7:0]        b;
        bit                typed;
        pwmd_pkg::result_t res;
        bit                pause;
    } stream_item_t;

    localparam logic [7:0] ID_CHOKE = 8'd0;
    // The error field reads zero on every result that is not an error.
    localparam pwmd_pkg::err_t NO_ERR = pwmd_pkg::ERR_TOO_LONG;
    // Register index that the block decodes to nothing.
    localparam logic [pwmd_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic [pwmd_pkg::CFG_DATA_BITS-1:0] LIMIT_TOP = 21'd1048576;
    localparam int STALL_LIMIT = 2000;
    localparam int BYTES_PER_PHASE = 300;

    logic clk;
    logic rst_n;

    pwmd_byte_if   byte_ch ();
    pwmd_result_if res_ch ();
    pwmd_cfg_if    cfg_ch ();

    peer_wire_message_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .byte_in   (byte_ch),
        .result_out(res_ch)
    );

    // Model state and its copy of the registers.
    phase_t      wire_phase;
    int          len_count;
    logic [31:0] frame_len;
    logic [31:0] bytes_left;
    logic [7:0]  frame_id;
    logic [31:0] index_acc;
    logic [31:0] begin_acc;
    bit          parser_dead;
    logic [31:0] lim_frame;
    logic [31:0] lim_bf;

    stream_item_t      byte_q[$];
    pwmd_pkg::result_t expected_q[$];

    int send_idle;
    int recv_idle;
    int n_pushed;
    int n_frames;
    int n_bytes;
    int n_results;
    int n_fail;
    int n_settings;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic pwmd_pkg::result_t mk(pwmd_pkg::kind_t k, logic [7:0] id,
                                             logic [31:0] ix, logic [31:0] bg,
                                             logic [7:0] d, logic [19:0] o,
                                             logic l, pwmd_pkg::err_t e);
        pwmd_pkg::result_t x;
        x.kind        = k;
        x.msg_id      = id;
        x.piece_num   = ix;
        x.block_begin = bg;
        x.data_byte   = d;
        x.byte_offset = o;
        x.last        = l;
        x.error_code  = e;
        return x;
    endfunction

    function automatic stream_item_t plain(logic [7:0] b);
        stream_item_t it;
        it.b     = b;
        it.typed = 1'b0;
        it.res   = '0;
        it.pause = 1'b0;
        return it;
    endfunction

    function automatic stream_item_t with_result(logic [7:0] b, pwmd_pkg::result_t r);
        stream_item_t it;
        it       = plain(b);
        it.typed = 1'b1;
        it.res   = r;
        return it;
    endfunction

    task automatic model_reset();
        wire_phase  = AWAIT_LEN;
        len_count   = 0;
        frame_len   = '0;
        bytes_left  = '0;
        frame_id    = '0;
        index_acc   = '0;
        begin_acc   = '0;
        parser_dead = 1'b0;
        lim_frame   = {11'd0, pwmd_pkg::MAX_FRAME_RESET};
        lim_bf      = {11'd0, pwmd_pkg::MAX_BITFIELD_RESET};
    endtask

    // Advance the parser model by one stream byte and give the result it causes.
    task automatic parse_byte(input logic [7:0] b, output bit has,
                              output pwmd_pkg::result_t r);
        bit             fail_now;
        bit             finish;
        pwmd_pkg::err_t code;
        logic [7:0]     err_id;
        logic [31:0]    fin_idx;
        logic [31:0]    pos;
        has      = 1'b0;
        r        = '0;
        fail_now = 1'b0;
        finish   = 1'b0;
        code     = NO_ERR;
        err_id   = b;
        fin_idx  = '0;
        if (!parser_dead)
        begin
            case (wire_phase)
                AWAIT_LEN:
                begin
                    frame_len = {frame_len[23:0], b};
                    if (len_count < 3)
                        len_count++;
                    else
                    begin
                        len_count = 0;
                        if (frame_len > lim_frame)
                        begin
                            fail_now = 1'b1;
                            code     = pwmd_pkg::ERR_TOO_LONG;
                            err_id   = 8'd0;
                        end
                        else if (frame_len == 0)
                        begin
                            has = 1'b1;
                            r   = mk(pwmd_pkg::KIND_KEEPALIVE, 8'd0, '0, '0, '0, '0,
                                     1'b1, NO_ERR);
                        end
                        else
                            wire_phase = AWAIT_ID;
                    end
                end
                AWAIT_ID:
                begin
                    frame_id  = b;
                    index_acc = '0;
                    begin_acc = '0;
                    if (b <= pwmd_pkg::ID_LAST_CONTROL)
                    begin
                        fail_now = (frame_len != 1);
                        finish   = !fail_now;
                        code     = pwmd_pkg::ERR_FIXED_LENGTH;
                    end
                    else if (b == pwmd_pkg::ID_HAVE)
                    begin
                        fail_now   = (frame_len != 5);
                        code       = pwmd_pkg::ERR_FIXED_LENGTH;
                        bytes_left = 32'd4;
                        wire_phase = HAVE_INDEX;
                    end
                    else if (b == pwmd_pkg::ID_REQUEST || b == pwmd_pkg::ID_CANCEL)
                    begin
                        fail_now   = (frame_len != 13);
                        code       = pwmd_pkg::ERR_FIXED_LENGTH;
                        bytes_left = 32'd12;
                        wire_phase = SKIP_PAYLOAD;
                    end
                    else if (b == pwmd_pkg::ID_BITFIELD)
                    begin
                        fail_now   = (frame_len - 32'd1 > lim_bf);
                        code       = pwmd_pkg::ERR_BITFIELD;
                        finish     = !fail_now && frame_len == 1;
                        bytes_left = frame_len - 32'd1;
                        wire_phase = BITFIELD_DATA;
                    end
                    else if (b == pwmd_pkg::ID_PIECE)
                    begin
                        fail_now   = (frame_len < 9);
                        code       = pwmd_pkg::ERR_PIECE_SHORT;
                        bytes_left = 32'd8;
                        wire_phase = PIECE_HEADER;
                    end
                    else
                    begin
                        // Unknown ids: skip the payload.
                        finish     = (frame_len == 1);
                        bytes_left = frame_len - 32'd1;
                        wire_phase = SKIP_PAYLOAD;
                    end
                end
                HAVE_INDEX:
                begin
                    index_acc = {index_acc[23:0], b};
                    bytes_left--;
                    finish  = (bytes_left == 0);
                    fin_idx = index_acc;
                end
                PIECE_HEADER:
                begin
                    if (bytes_left > 4)
                        index_acc = {index_acc[23:0], b};
                    else
                        begin_acc = {begin_acc[23:0], b};
                    bytes_left--;
                    if (bytes_left == 0)
                    begin
                        if (frame_len == 9)
                        begin
                            wire_phase = AWAIT_LEN;
                            has        = 1'b1;
                            r = mk(pwmd_pkg::KIND_EMPTY_PIECE, frame_id, index_acc,
                                   begin_acc, '0, '0, 1'b1, NO_ERR);
                        end
                        else
                        begin
                            bytes_left = frame_len - 32'd9;
                            wire_phase = PIECE_DATA;
                        end
                    end
                end
                BITFIELD_DATA, PIECE_DATA:
                begin
                    if (wire_phase == BITFIELD_DATA)
                        pos = frame_len - 32'd1 - bytes_left;
                    else
                        pos = frame_len - 32'd9 - bytes_left;
                    bytes_left--;
                    has = 1'b1;
                    if (wire_phase == BITFIELD_DATA)
                        r = mk(pwmd_pkg::KIND_BITFIELD, frame_id, '0, '0, b, pos[19:0],
                               bytes_left == 0, NO_ERR);
                    else
                        r = mk(pwmd_pkg::KIND_PIECE, frame_id, index_acc, begin_acc, b,
                               pos[19:0], bytes_left == 0, NO_ERR);
                    if (bytes_left == 0)
                        wire_phase = AWAIT_LEN;
                end
                SKIP_PAYLOAD:
                begin
                    if (bytes_left > 0)
                        bytes_left--;
                    finish = (bytes_left == 0);
                end
                default:
                begin
                end
            endcase
            if (fail_now)
            begin
                wire_phase  = DEAD;
                parser_dead = 1'b1;
                has         = 1'b1;
                r           = mk(pwmd_pkg::KIND_ERROR, err_id, '0, '0, '0, '0, 1'b1, code);
            end
            else if (finish)
            begin
                wire_phase = AWAIT_LEN;
                has        = 1'b1;
                r          = mk(pwmd_pkg::KIND_DONE, frame_id, fin_idx, '0, '0, '0, 1'b1,
                                NO_ERR);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (n_fail < 40)
            $display("mismatch at %0t ns: %s", $time, msg);
        n_fail++;
    endtask

    task automatic cmp_field(input string field, input logic [31:0] g, input logic [31:0] w);
        if (g !== w)
            report_mismatch($sformatf("%s is %0h, expected %0h (result %0d)",
                                      field, g, w, n_results));
    endtask

    task automatic check_result(input pwmd_pkg::result_t got);
        pwmd_pkg::result_t want;
        n_results++;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("result of kind %0d with nothing pending", got.kind));
            return;
        end
        want = expected_q.pop_front();
        cmp_field("kind", got.kind, want.kind);
        cmp_field("msg_id", got.msg_id, want.msg_id);
        cmp_field("piece_num", got.piece_num, want.piece_num);
        cmp_field("block_begin", got.block_begin, want.block_begin);
        cmp_field("data_byte", got.data_byte, want.data_byte);
        cmp_field("byte_offset", got.byte_offset, want.byte_offset);
        cmp_field("last", got.last, want.last);
        cmp_field("error_code", got.error_code, want.error_code);
    endtask

    // Stream building. A byte now and then waits for all pending results first.
    task automatic push_byte(input logic [7:0] b);
        stream_item_t it;
        it       = plain(b);
        it.pause = (n_pushed % 250 == 125);
        byte_q.push_back(it);
        n_pushed++;
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            push_byte($urandom_range(0, 255));
    endtask

    task automatic push_word(input logic [31:0] w);
        push_byte(w[31:24]);
        push_byte(w[23:16]);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endtask

    task automatic push_len(input logic [31:0] len);
        push_word(len);
        n_frames++;
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Mostly short payloads, now and then a longer one.
    function automatic int pick_size();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(13, 600);
        return $urandom_range(0, 12);
    endfunction

    // Queue one well-formed frame that fits the current limits.
    task automatic push_frame();
        int pick;
        int n;
        int cap;
        pick = $urandom_range(0, 9);
        if (pick == 2 && lim_frame >= 5)
        begin
            push_len(5);
            push_byte(pwmd_pkg::ID_HAVE);
            push_word(pick_word());
        end
        else if (pick == 3 && lim_frame >= 13)
        begin
            push_len(13);
            push_byte($urandom_range(0, 1) ? pwmd_pkg::ID_REQUEST : pwmd_pkg::ID_CANCEL);
            push_random(12);
        end
        else if (pick == 4 || pick == 5)
        begin
            cap = (lim_bf < lim_frame - 1) ? lim_bf : lim_frame - 1;
            n   = pick_size();
            if (n > cap)
                n = $urandom_range(0, cap);
            push_len(n + 1);
            push_byte(pwmd_pkg::ID_BITFIELD);
            push_random(n);
        end
        else if ((pick == 6 || pick == 7) && lim_frame >= 9)
        begin
            cap = lim_frame - 9;
            n   = pick_size();
            if (n > cap)
                n = $urandom_range(0, cap);
            push_len(n + 9);
            push_byte(pwmd_pkg::ID_PIECE);
            push_word(pick_word());
            push_word(pick_word());
            push_random(n);
        end
        else if (pick == 8)
        begin
            cap = lim_frame - 1;
            n   = $urandom_range(0, 10);
            if (n > cap)
                n = cap;
            push_len(n + 1);
            push_byte($urandom_range(pwmd_pkg::ID_CANCEL + 1, 255));
            push_random(n);
        end
        else if (pick == 0)
            push_len(0);
        else
        begin
            push_len(1);
            push_byte($urandom_range(0, pwmd_pkg::ID_LAST_CONTROL));
        end
    endtask

    task automatic fill_random(input int target);
        int start;
        start = n_pushed;
        while (n_pushed - start < target)
            push_frame();
    endtask

    // Wait until every byte is taken and every pending result has arrived.
    task automatic wait_stream_idle();
        @(posedge clk);
        while (byte_q.size() != 0 || byte_ch.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pwmd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [pwmd_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == pwmd_pkg::CFG_MAX_FRAME)
            lim_frame = {11'd0, val};
        else if (idx == pwmd_pkg::CFG_MAX_BITFIELD)
            lim_bf = {11'd0, val};
    endtask

    task automatic apply_limits(input logic [pwmd_pkg::CFG_DATA_BITS-1:0] mf,
                                input logic [pwmd_pkg::CFG_DATA_BITS-1:0] mb);
        write_reg(pwmd_pkg::CFG_MAX_FRAME, mf);
        write_reg(pwmd_pkg::CFG_MAX_BITFIELD, mb);
        n_settings++;
    endtask

    // Byte sender: one transaction per accepted byte, updating the model on acceptance.
    initial
    begin : byte_sender
        stream_item_t      cur;
        bit                has;
        bit                busy;
        pwmd_pkg::result_t r;
        byte_ch.valid       <= 1'b0;
        byte_ch.stream_byte <= '0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                busy = byte_ch.valid;
                if (byte_ch.valid && byte_ch.ready)
                begin
                    parse_byte(cur.b, has, r);
                    if (cur.typed)
                        expected_q.push_back(cur.res);
                    else if (has)
                        expected_q.push_back(r);
                    n_bytes++;
                    busy = 1'b0;
                end
                if (!busy)
                begin
                    if (byte_q.size() != 0 && !(byte_q[0].pause && expected_q.size() != 0)
                        && $urandom_range(0, 99) >= send_idle)
                    begin
                        cur = byte_q.pop_front();
                        byte_ch.valid       <= 1'b1;
                        byte_ch.stream_byte <= cur.b;
                    end
                    else
                        byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random back-pressure.
    initial
    begin : result_receiver
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Compare each result transaction with the oldest pending expectation.
    always @(posedge clk)
    begin : result_monitor
        pwmd_pkg::result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.kind        = res_ch.kind;
            got.msg_id      = res_ch.msg_id;
            got.piece_num   = res_ch.piece_num;
            got.block_begin = res_ch.block_begin;
            got.data_byte   = res_ch.data_byte;
            got.byte_offset = res_ch.byte_offset;
            got.last        = res_ch.last;
            got.error_code  = res_ch.error_code;
            check_result(got);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence: directed frames, random phases under several limits, final error.
    initial
    begin : main_sequence
        stream_item_t directed_rows [23];
        logic [pwmd_pkg::CFG_DATA_BITS-1:0] mf;
        logic [pwmd_pkg::CFG_DATA_BITS-1:0] mb;
        logic [31:0] bad_len;
        logic [7:0]  bad_id;
        int          err_pick;
        int          k;
        send_idle    = 0;
        recv_idle    = 0;
        n_pushed     = 0;
        n_frames     = 0;
        n_bytes      = 0;
        n_results    = 0;
        n_fail       = 0;
        n_settings   = 1;
        stall_cycles = 0;
        model_reset();
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= pwmd_pkg::CFG_MAX_FRAME;
        cfg_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset limits: keep-alive, choke, empty bitfield
        // and a have message with the largest index.
        directed_rows = '{
            plain(8'h00), plain(8'h00), plain(8'h00),
            with_result(8'h00, mk(pwmd_pkg::KIND_KEEPALIVE, 8'd0, '0, '0, '0, '0, 1'b1,
                                  NO_ERR)),
            plain(8'h00), plain(8'h00), plain(8'h00), plain(8'h01),
            with_result(ID_CHOKE, mk(pwmd_pkg::KIND_DONE, ID_CHOKE, '0, '0, '0, '0, 1'b1,
                                     NO_ERR)),
            plain(8'h00), plain(8'h00), plain(8'h00), plain(8'h01),
            with_result(pwmd_pkg::ID_BITFIELD,
                        mk(pwmd_pkg::KIND_DONE, pwmd_pkg::ID_BITFIELD, '0, '0, '0, '0,
                           1'b1, NO_ERR)),
            plain(8'h00), plain(8'h00), plain(8'h00), plain(8'h05),
            plain(pwmd_pkg::ID_HAVE),
            plain(8'hFF), plain(8'hFF), plain(8'hFF),
            with_result(8'hFF,
                        mk(pwmd_pkg::KIND_DONE, pwmd_pkg::ID_HAVE, 32'hFFFF_FFFF, '0, '0,
                           '0, 1'b1, NO_ERR))
        };
        send_idle = 13;
        recv_idle = 87;
        foreach (directed_rows[i])
            byte_q.push_back(directed_rows[i]);
        fill_random(BYTES_PER_PHASE);
        wait_stream_idle();

        // Random phases, each under its own limits.
        for (int p = 1; p < 6; p++)
        begin
            case (p)
                1:
                begin
                    mf = LIMIT_TOP;
                    mb = LIMIT_TOP;
                end
                2:
                begin
                    mf = 21'd1;
                    mb = 21'd0;
                end
                3:
                begin
                    mf = $urandom_range(9, 64);
                    mb = $urandom_range(0, 20);
                end
                4:
                begin
                    mf = 21'd13;
                    mb = 21'd0;
                end
                default:
                begin
                    mf = $urandom_range(13, LIMIT_TOP);
                    mb = $urandom_range(0, LIMIT_TOP);
                end
            endcase
            if (p < 2)
            begin
                send_idle = 13;
                recv_idle = 87;
            end
            else if (p < 4)
            begin
                send_idle = 87;
                recv_idle = 13;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            apply_limits(mf, mb);
            if (p == 2)
                write_reg(CFG_UNUSED, $urandom_range(0, LIMIT_TOP));
            fill_random(BYTES_PER_PHASE);
            wait_stream_idle();
        end

        // Last phase ends on a broken frame; everything after it must be dropped.
        apply_limits($urandom_range(600, LIMIT_TOP), $urandom_range(0, 500));
        fill_random(60);
        err_pick = $urandom_range(0, 3);
        bad_id   = ID_CHOKE;
        case (err_pick)
            0:
            begin
                if ($urandom_range(0, 1))
                    bad_len = 32'hFFFF_FFFF - $urandom_range(0, 255);
                else
                    bad_len = lim_frame + 32'd1;
            end
            1:
            begin
                k = $urandom_range(0, 2);
                if (k == 0)
                begin
                    bad_id  = $urandom_range(0, pwmd_pkg::ID_LAST_CONTROL);
                    bad_len = $urandom_range(2, 12);
                end
                else if (k == 1)
                begin
                    bad_id  = pwmd_pkg::ID_HAVE;
                    bad_len = $urandom_range(6, 12);
                end
                else
                begin
                    bad_id  = $urandom_range(0, 1) ? pwmd_pkg::ID_REQUEST
                                                   : pwmd_pkg::ID_CANCEL;
                    bad_len = $urandom_range(1, 12);
                end
            end
            2:
            begin
                bad_id  = pwmd_pkg::ID_PIECE;
                bad_len = $urandom_range(1, 8);
            end
            default:
            begin
                bad_id  = pwmd_pkg::ID_BITFIELD;
                bad_len = lim_bf + 32'd2 + $urandom_range(0, 9);
            end
        endcase
        push_len(bad_len);
        if (err_pick != 0)
            push_byte(bad_id);
        push_random(16);
        wait_stream_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d stream bytes in %0d frames and %0d results over %0d limit settings",
                 n_bytes, n_frames, n_results, n_settings);
        $display("closing broken frame raised error code %0d; %0d mismatches", err_pick, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pwmd_pkg.sv
sv/pwmd_if.sv
sv/pwmd_parser.sv
sv/pwmd_out_skid.sv
sv/peer_wire_message_deframer.sv
tb/peer_wire_message_deframer_test.sv
